FILE: src/ttrc_pkg.sv
// Constants and widths shared by the three-term recurrence checksum unit.
// No dependencies; imported by the top level.
package ttrc_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned TERM_W = 16;
   localparam int unsigned COEF_W = 5;

   // Offset added to the first byte of a message.
   localparam logic [TERM_W-1:0] FIRST_OFFSET = 16'd7;
   // Position multipliers for alpha and beta (taken modulo 256).
   localparam logic [COEF_W-1:0] ALPHA_MUL = 5'd17;
   localparam logic [COEF_W-1:0] BETA_MUL  = 5'd31;
   // Checksum modulus, 2^16 - 1.
   localparam logic [TERM_W-1:0] MODULUS   = 16'hFFFF;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [TERM_W-1:0] term_type;

endpackage

FILE: src/three_term_recurrence_checksum_unit.sv
// Three-term recurrence checksum over a byte stream: request register, one
// recurrence step with modulo-65535 reduction, and a result register.
// Depends on ttrc_pkg.
//
//  channel | direction | tdata (low bit up) | tuser | tlast
//  req     | in        | data_byte[7:0]     | -     | last_byte
//  rsp     | out       | checksum[15:0]     | -     | -
//
// One request per cycle is taken, sustained, unless a last byte waits on a held
// checksum. A checksum appears once the request carrying tlast has passed from
// the request register through the recurrence step (two small multipliers, a
// subtract and a fold modulo 65535) into the result register, if the result
// slot is free.
// Reset is synchronous, active high, and leaves the unit awaiting the first
// byte of a message. Only a last byte waits on a stalled result channel;
// other bytes keep flowing while an earlier checksum is still held.

module three_term_recurrence_checksum_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  ttrc_pkg::byte_type      req_tdata,   // [7:0] data_byte
   input  logic                    req_tlast,   // last_byte
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output ttrc_pkg::term_type      rsp_tdata    // [15:0] checksum
);
   import ttrc_pkg::*;

   localparam int unsigned A_W    = BYTE_W + 1;        // byte + alpha
   localparam int unsigned PROD_W = A_W + TERM_W;      // widest product
   localparam int unsigned POS_W  = BYTE_W + COEF_W;   // position * multiplier
   localparam int unsigned FOLD_W = TERM_W + 1;

   // Request register
   logic     in_valid_ff, in_valid_in;
   logic     in_last_ff;
   byte_type in_byte_ff;

   // Recurrence state
   term_type       older_ff, older_in;
   term_type       newer_ff, newer_in;
   logic [7:0]     pos_ff, pos_in;
   logic           awaiting_first_ff, awaiting_first_in;

   // Result register
   logic     rsp_valid_ff, rsp_valid_in;
   term_type rsp_data_ff;

   logic     advance;   // the held request moves through the step this cycle
   logic     take_req;
   logic     emit;

   logic [POS_W-1:0]  alpha_prod, beta_prod;
   logic [BYTE_W-1:0] alpha, beta;
   logic [A_W-1:0]    a_sum;
   logic [PROD_W-1:0] prod_p, prod_q, mag;
   logic              non_neg;
   logic [FOLD_W-1:0] fold;
   term_type          mag_mod, step_val, next_term;

   // A last byte needs a free result slot; any other byte always moves on.
   assign advance  = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign emit     = advance && in_last_ff;
   assign take_req = req_tvalid && req_tready;

   // Accept whenever the request register is empty or is being drained.
   assign req_tready = !in_valid_ff || advance;

   // alpha and beta are the position times 17 and 31, modulo 256.
   assign alpha_prod = POS_W'(pos_ff) * POS_W'(ALPHA_MUL);
   assign beta_prod  = POS_W'(pos_ff) * POS_W'(BETA_MUL);
   assign alpha      = alpha_prod[BYTE_W-1:0];
   assign beta       = beta_prod[BYTE_W-1:0];
   assign a_sum      = A_W'(in_byte_ff) + A_W'(alpha);

   assign prod_p  = PROD_W'(a_sum) * PROD_W'(newer_ff);
   assign prod_q  = PROD_W'(beta) * PROD_W'(older_ff);
   assign non_neg = (prod_p >= prod_q);

   // For a negative difference -x the 64-bit wrap leaves (1 - x) mod 65535,
   // i.e. -(x - 1); keep the magnitude and negate after the reduction.
   assign mag = non_neg ? (prod_p - prod_q) : (prod_q - prod_p - PROD_W'(1));

   // 2^16 is 1 mod 65535: fold the high part onto the low half, then one
   // conditional subtract brings it below the modulus.
   assign fold    = FOLD_W'(mag[PROD_W-1:TERM_W]) + FOLD_W'(mag[TERM_W-1:0]);
   assign mag_mod = (fold >= FOLD_W'(MODULUS)) ? TERM_W'(fold - FOLD_W'(MODULUS))
                                               : fold[TERM_W-1:0];

   always_comb begin
      if (non_neg || (mag_mod == '0)) begin
         step_val = mag_mod;
      end else begin
         step_val = MODULUS - mag_mod;
      end
   end

   // The first byte of a message seeds the newer term directly.
   assign next_term = awaiting_first_ff ? (TERM_W'(in_byte_ff) + FIRST_OFFSET) : step_val;

   always_comb begin
      older_in          = older_ff;
      newer_in          = newer_ff;
      pos_in            = pos_ff;
      awaiting_first_in = awaiting_first_ff;
      if (advance) begin
         if (in_last_ff) begin
            // Message done: back to the reset state for the next one.
            older_in          = TERM_W'(1);
            newer_in          = '0;
            pos_in            = '0;
            awaiting_first_in = 1'b1;
         end else begin
            older_in          = awaiting_first_ff ? TERM_W'(1) : newer_ff;
            newer_in          = next_term;
            pos_in            = pos_ff + 8'd1;
            awaiting_first_in = 1'b0;
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take_req) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and recurrence state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         older_ff          <= TERM_W'(1);
         newer_ff          <= '0;
         pos_ff            <= '0;
         awaiting_first_ff <= 1'b1;
      end else begin
         in_valid_ff       <= in_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         older_ff          <= older_in;
         newer_ff          <= newer_in;
         pos_ff            <= pos_in;
         awaiting_first_ff <= awaiting_first_in;
      end
   end

   // Payload: load on acceptance, hold otherwise
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (emit) begin
         rsp_data_ff <= next_term;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A checksum only appears after a last byte went through the step.
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff && in_last_ff))
      else $error("checksum raised without a last byte");

   // Finishing a message returns the recurrence to its starting point.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      emit |=> (awaiting_first_ff && (pos_ff == '0) && (older_ff == TERM_W'(1))))
      else $error("state not restarted after last byte");

   // A last byte blocked by a held checksum stays in the request register.
   a_last_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_last_ff && rsp_valid_ff && !rsp_tready) |=>
         (in_valid_ff && in_last_ff))
      else $error("blocked last byte lost");

   // Reduced terms never reach the modulus itself.
   a_term_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff != MODULUS))
      else $error("checksum out of range");

endmodule

FILE: dv/checksum_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the three-term recurrence checksum unit. It watches both stream
// channels, predicts each checksum from the accepted bytes and compares them.
// Depends on ttrc_pkg for the port types.
module checksum_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  ttrc_pkg::byte_type req_tdata,   // [7:0] data_byte
   input  logic               req_tlast,   // last_byte
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  ttrc_pkg::term_type rsp_tdata,   // [15:0] checksum
   output int                 mismatch_count,
   output int                 checksums_pending
);
   import ttrc_pkg::*;

   localparam logic [15:0] OPENING_ADD = 16'd7;
   localparam logic [63:0] ALPHA_STEP  = 64'd17;
   localparam logic [63:0] BETA_STEP   = 64'd31;
   localparam logic [63:0] FOLD_MOD    = 64'd65535;

   term_type   older_q;
   term_type   newer_q;
   logic [7:0] position_q;
   logic       fresh_message;
   term_type   checksums_due[$];
   int         errors = 0;

   // One recurrence step in 64-bit wraparound, folded modulo 65535.
   function automatic term_type fold_step(input byte_type data, input logic [7:0] pos,
                                          input term_type newer, input term_type older);
      logic [63:0] wide_pos, wide_data, wide_newer, wide_older;
      logic [63:0] alpha, beta, diff;
      wide_pos   = pos;
      wide_data  = data;
      wide_newer = newer;
      wide_older = older;
      alpha = (wide_pos * ALPHA_STEP) & 64'hFF;
      beta  = (wide_pos * BETA_STEP) & 64'hFF;
      diff  = (wide_data + alpha) * wide_newer - beta * wide_older;
      return term_type'(diff % FOLD_MOD);
   endfunction

   always @(posedge clock) begin
      term_type want;
      term_type advanced;
      if (reset) begin
         older_q       = 16'd1;
         newer_q       = '0;
         position_q    = '0;
         fresh_message = 1'b1;
         checksums_due.delete();
      end else begin
         // A checksum leaving now cannot stem from a byte taken at this edge.
         if (rsp_tvalid && rsp_tready) begin
            if (checksums_due.size() == 0) begin
               $display("%0t: unexpected checksum, expected none, actual %0d",
                        $time, rsp_tdata);
               errors++;
            end else begin
               want = checksums_due.pop_front();
               if (rsp_tdata !== want) begin
                  $display("%0t: checksum mismatch, expected %0d, actual %0d",
                           $time, want, rsp_tdata);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (fresh_message) begin
               newer_q       = {8'd0, req_tdata} + OPENING_ADD;
               older_q       = 16'd1;
               fresh_message = 1'b0;
            end else begin
               advanced = fold_step(req_tdata, position_q, newer_q, older_q);
               older_q  = newer_q;
               newer_q  = advanced;
            end
            position_q = position_q + 8'd1;
            if (req_tlast) begin
               checksums_due.push_back(newer_q);
               older_q       = 16'd1;
               newer_q       = '0;
               position_q    = '0;
               fresh_message = 1'b1;
            end
         end
      end
      mismatch_count    <= errors;
      checksums_pending <= checksums_due.size();
   end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Top of the checksum unit test: clock, reset, request stimulus, result
// back-pressure and the verdict. Depends on ttrc_pkg,
// three_term_recurrence_checksum_unit and checksum_checker.
module testbench;
   import ttrc_pkg::*;

   // Back-pressure styles for the result channel.
   typedef enum int {ALWAYS_READY, MOSTLY_READY, MOSTLY_STALLED, TOGGLING} stall_mode_type;

   localparam int LONG_HOLD_CYCLES = 400;
   localparam int RANDOM_ITEMS     = 400;
   localparam int MIN_MESSAGES     = 40;
   localparam int DIRECTED_COUNT   = 19;

   // Directed messages: single bytes at both extremes, a message whose third
   // step goes negative before the fold, all-zero and all-ones messages, and
   // one with alternating bit patterns.
   localparam byte_type DIRECTED_BYTES [DIRECTED_COUNT] = '{
      8'd0,
      8'd255,
      8'd255, 8'd234, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0,
      8'd255, 8'd255, 8'd255, 8'd255,
      8'h55, 8'hAA, 8'h01, 8'h80, 8'hFE, 8'h7F
   };
   localparam bit DIRECTED_LAST [DIRECTED_COUNT] = '{
      1'b1,
      1'b1,
      1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1
   };

   logic     clock;
   logic     reset;
   logic     req_tvalid;
   logic     req_tready;
   byte_type req_tdata;
   logic     req_tlast;
   logic     rsp_tvalid;
   logic     rsp_tready;
   term_type rsp_tdata;
   int       failures;
   int       outstanding;

   int burst_left    = 0;
   bit gaps_on       = 1'b1;
   bit long_hold_due = 1'b0;
   int items_sent    = 0;

   three_term_recurrence_checksum_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   checksum_checker scoreboard (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tlast         (req_tlast),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .mismatch_count    (failures),
      .checksums_pending (outstanding)
   );

   // 12 ns period.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Offer one request and hold it until the unit takes it. Between bursts of
   // random length, sometimes drop valid for a random gap; with gaps switched off the
   // bursts run back to back.
   task automatic offer_byte(input byte_type data, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = (gaps_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      // Both signals are sampled as they stood just before the edge.
      do @(posedge clock); while (!req_tready);
      burst_left--;
      items_sent++;
   endtask

   // Send a whole message of random bytes, tlast on the final one.
   task automatic send_message(input int length);
      for (int i = 0; i < length; i++)
         offer_byte(byte_type'($urandom_range(0, 255)), i == length - 1);
   endtask

   // Pause the sender until every predicted checksum has come back. Let a clock
   // edge pass first so the scoreboard's count covers the last request taken.
   task automatic wait_for_checksums();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      burst_left = 0;
   endtask

   // Result side: one long hold-off when asked for, otherwise a stall pattern
   // that changes style after each span of random length, including stretches
   // with no stalls at all.
   initial begin
      int             hold_left;
      int             span;
      stall_mode_type mode;
      hold_left = 0;
      span      = 0;
      mode      = ALWAYS_READY;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            hold_left     = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (span == 0) begin
               mode = stall_mode_type'($urandom_range(0, 3));
               span = $urandom_range(10, 60);
            end
            span--;
            case (mode)
               ALWAYS_READY: begin
                  rsp_tready <= 1'b1;
               end
               MOSTLY_READY: begin
                  rsp_tready <= ($urandom_range(0, 3) != 0);
               end
               MOSTLY_STALLED: begin
                  rsp_tready <= ($urandom_range(0, 3) == 0);
               end
               default: begin
                  rsp_tready <= ~rsp_tready;
               end
            endcase
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      int  first_random;
      int  messages;
      int  pick;
      bit  long_done;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed requests, then drain so the random part starts from idle.
      for (int i = 0; i < DIRECTED_COUNT; i++)
         offer_byte(DIRECTED_BYTES[i], DIRECTED_LAST[i]);
      wait_for_checksums();

      // Random messages. Hold the result channel off at the start so that
      // a checksum backs up and the unit stalls its request side. One message
      // runs past 256 bytes to wrap the position counter; the rest are short.
      long_hold_due = 1'b1;
      first_random  = items_sent;
      messages      = 0;
      long_done     = 1'b0;
      while (items_sent - first_random < RANDOM_ITEMS || messages < MIN_MESSAGES) begin
         gaps_on = ($urandom_range(0, 4) != 0);
         pick    = $urandom_range(0, 99);
         if (!long_done && items_sent - first_random > 100) begin
            send_message($urandom_range(257, 300));
            long_done = 1'b1;
         end else if (pick < 80) begin
            send_message($urandom_range(1, 5));
         end else begin
            send_message($urandom_range(6, 20));
         end
         messages++;
         if ($urandom_range(0, 14) == 0)
            wait_for_checksums();
      end

      // Drain, then keep the clock running so anything stray still shows.
      wait_for_checksums();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #(2_000_000);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
